// ===== rtl/core/llp_pkg.sv =====
// ----------------------------------------------------------------------------
// llp_pkg
// Shared types and constants for the long integer literal parser.
// ----------------------------------------------------------------------------
package llp_pkg;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;

    localparam logic [1:0] POS_IDLE  = 2'd0;
    localparam logic [1:0] POS_FIRST = 2'd1;
    localparam logic [1:0] POS_BODY  = 2'd2;
    localparam logic [1:0] POS_DONE  = 2'd3;

    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_NINE    = 7'h39;
    localparam logic [6:0] CH_UP_A    = 7'h41;
    localparam logic [6:0] CH_UP_F    = 7'h46;
    localparam logic [6:0] CH_LO_A    = 7'h61;
    localparam logic [6:0] CH_LO_F    = 7'h66;
    localparam logic [6:0] CH_UP_L    = 7'h4C;
    localparam logic [6:0] CH_LO_L    = 7'h6C;
    localparam logic [6:0] CH_UP_X    = 7'h58;
    localparam logic [6:0] CH_LO_X    = 7'h78;

    localparam logic [63:0] DEC_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DEC_LIMIT = DEC_MAX / 64'd10;

    localparam logic [4:0] HEX_DIGITS = 5'd16;
    localparam logic [4:0] OCT_DIGITS = 5'd22;

    typedef struct packed {
        logic [63:0] accum;
        logic [1:0]  base_kind;
        logic        neg_flag;
        logic        overflow_flag;
        logic [4:0]  sig_digits;
        logic [2:0]  lead_digit;
        logic [1:0]  char_pos;
    } llp_state_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               bad;
        logic [1:0]         radix;
    } llp_result_t;

    function automatic logic [3:0] digit_of(input logic [6:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 4'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            d = 4'(c - CH_LO_A + 7'd10);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = 4'(c - CH_UP_A + 7'd10);
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/llp_step.sv =====
// ----------------------------------------------------------------------------
// llp_step
// Next-state and result logic for one character of a literal.
// ----------------------------------------------------------------------------
module llp_step
    import llp_pkg::*;
(
    input  llp_state_t  state_i,
    input  logic [6:0]  ch,
    input  logic        first,
    input  logic        negate,
    output llp_state_t  state_o,
    output logic        emit_o,
    output llp_result_t result_o
);

    logic        start;
    logic        is_suffix;
    logic        is_x;
    logic [3:0]  d;
    logic [3:0]  dd;
    logic [2:0]  d3;
    logic        top_ok;
    logic [63:0] times_ten;
    logic [4:0]  sig_inc;

    assign start     = first || (state_i.char_pos == POS_IDLE);
    assign is_suffix = (ch == CH_UP_L) || (ch == CH_LO_L);
    assign is_x      = (ch == CH_UP_X) || (ch == CH_LO_X);
    assign d         = digit_of(ch);
    assign dd        = (d > 4'd9) ? 4'd9 : d;
    assign d3        = d[2:0];

    always_comb begin
        state_o  = state_i;
        emit_o   = 1'b0;
        result_o = '0;
        if (start) begin
            state_o.accum         = '0;
            state_o.base_kind     = RADIX_DEC;
            state_o.neg_flag      = negate;
            state_o.overflow_flag = 1'b0;
            state_o.sig_digits    = '0;
            state_o.lead_digit    = '0;
            state_o.char_pos      = POS_FIRST;
        end
        top_ok    = (dd <= (state_o.neg_flag ? 4'd8 : 4'd7));
        times_ten = (state_o.accum << 3) + (state_o.accum << 1) + {60'd0, dd};
        sig_inc   = state_o.sig_digits + 5'd1;
        if (start || state_i.char_pos != POS_DONE) begin
            if (is_suffix) begin
                emit_o          = 1'b1;
                result_o.bad    = state_o.overflow_flag;
                result_o.radix  = state_o.base_kind;
                if (!state_o.overflow_flag) begin
                    result_o.value = state_o.neg_flag ? -state_o.accum : state_o.accum;
                end
                state_o.char_pos = POS_DONE;
            end else if (start && ch == CH_ZERO) begin
                state_o.base_kind = RADIX_OCT;
            end else if (!start && state_i.char_pos == POS_FIRST
                         && state_i.base_kind == RADIX_OCT && is_x) begin
                state_o.base_kind = RADIX_HEX;
                state_o.char_pos  = POS_BODY;
            end else begin
                if (!start) begin
                    state_o.char_pos = POS_BODY;
                end
                unique case (state_o.base_kind)
                    RADIX_HEX: begin
                        if (!(state_o.sig_digits == 5'd0 && d == 4'd0)) begin
                            if (state_o.sig_digits >= HEX_DIGITS) begin
                                state_o.overflow_flag = 1'b1;
                            end else begin
                                state_o.accum      = {state_o.accum[59:0], d};
                                state_o.sig_digits = sig_inc;
                            end
                        end
                    end
                    RADIX_OCT: begin
                        if (!(state_o.sig_digits == 5'd0 && d3 == 3'd0)) begin
                            if (state_o.sig_digits >= OCT_DIGITS) begin
                                state_o.overflow_flag = 1'b1;
                            end else begin
                                if (state_o.sig_digits == 5'd0) begin
                                    state_o.lead_digit = d3;
                                end
                                state_o.accum      = {state_o.accum[60:0], d3};
                                state_o.sig_digits = sig_inc;
                                if (sig_inc == OCT_DIGITS && state_o.lead_digit > 3'd1) begin
                                    state_o.overflow_flag = 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        if (!state_o.overflow_flag) begin
                            if (state_o.accum > DEC_LIMIT
                                || (state_o.accum == DEC_LIMIT && !top_ok)) begin
                                state_o.overflow_flag = 1'b1;
                            end else begin
                                state_o.accum = times_ten;
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/long_literal_parser_unit.sv =====
// ----------------------------------------------------------------------------
// long_literal_parser_unit
// Parses a 64-bit integer literal one character per transfer and returns
// its value, overflow flag and radix when the L/l suffix arrives.
//
//   channel  dir  tdata                              tuser
//   s_       in   [6:0] ch, [7] first, [8] negate     -
//   m_       out  [63:0] value                       [0] bad, [2:1] radix
//
// One character per cycle while s_tready is high; a result appears on m_
// in the cycle after the suffix transfer. Input and output are parted by
// the output register, so s_tready stays high while a held result is
// being taken. aresetn clears the parser state and the output valid. A
// stall on m_ drops s_tready only while a result waits and m_tready is low.
// ----------------------------------------------------------------------------
module long_literal_parser_unit
    import llp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] ch, [7] first, [8] negate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [2:0]  m_tuser    // [0] bad, [2:1] radix
);

    llp_state_t  state_reg;
    llp_state_t  state_next;
    llp_result_t result;
    logic        emit;
    logic        s_fire;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    llp_step u_step (
        .state_i  (state_reg),
        .ch       (s_tdata[6:0]),
        .first    (s_tdata[7]),
        .negate   (s_tdata[8]),
        .state_o  (state_next),
        .emit_o   (emit),
        .result_o (result)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg <= state_next;
            end
            if (s_fire && emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            m_tdata_reg <= result.value;
            m_tuser_reg <= {result.radix, result.bad};
        end
    end

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[0] |-> m_tdata_reg == 64'd0)
        else $error("bad result carries nonzero value");

    a_radix_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> m_tuser_reg[2:1] != 2'd3)
        else $error("illegal radix code");

    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && emit |=> state_reg.char_pos == POS_DONE && m_tvalid_reg)
        else $error("suffix did not close literal");

    a_sig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.sig_digits <= OCT_DIGITS)
        else $error("significant digit count out of range");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for long_literal_parser_unit. Streams integer literals
// one character per transfer: short directed cases first, then literals
// near the decimal, hex and octal range limits, then a random mix of
// well-formed literals, mangled ones and stray characters, then a stall-free
// burst. A behavioral parser inside the bench predicts every result; each
// result transfer is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import llp_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [6:0] ch, [7] first, [8] negate
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [63:0] value
    logic [2:0]  m_tuser;          // [0] bad, [2:1] radix

    // bench copy of the parser state
    logic [63:0] lit_accum = '0;
    logic [1:0]  lit_radix = RADIX_DEC;
    logic        lit_neg   = 1'b0;
    logic        lit_over  = 1'b0;
    logic [4:0]  lit_ndig  = '0;
    logic [2:0]  lit_lead  = '0;
    logic [1:0]  lit_pos   = POS_IDLE;

    llp_result_t parsed_values[$];
    llp_result_t want;
    int          error_count   = 0;
    int          chars_sent    = 0;
    int          cycle_count   = 0;
    bit          quiet         = 1'b0;

    long_literal_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [3:0] char_weight(input logic [6:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return c[3:0];
        end
        if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
            return {1'b0, c[2:0]} + 4'd9;
        end
        return 4'd0;
    endfunction

    task automatic parse_char(input logic [6:0] c, input logic f, input logic n);
        llp_result_t r;
        logic        fresh;
        logic [3:0]  d;
        fresh = 1'b0;
        if (f || lit_pos == POS_IDLE) begin
            lit_accum = '0;
            lit_radix = RADIX_DEC;
            lit_neg   = n;
            lit_over  = 1'b0;
            lit_ndig  = '0;
            lit_lead  = '0;
            lit_pos   = POS_FIRST;
            fresh     = 1'b1;
        end else if (lit_pos == POS_DONE) begin
            return;
        end
        if (c == CH_UP_L || c == CH_LO_L) begin
            r.value = lit_over ? 64'd0 : (lit_neg ? -lit_accum : lit_accum);
            r.bad   = lit_over;
            r.radix = lit_radix;
            parsed_values.push_back(r);
            lit_pos = POS_DONE;
            return;
        end
        if (fresh) begin
            if (c == CH_ZERO) begin
                lit_radix = RADIX_OCT;
                return;
            end
        end else begin
            if (lit_pos == POS_FIRST && lit_radix == RADIX_OCT
                    && (c == CH_LO_X || c == CH_UP_X)) begin
                lit_radix = RADIX_HEX;
                lit_pos   = POS_BODY;
                return;
            end
            lit_pos = POS_BODY;
        end
        d = char_weight(c);
        case (lit_radix)
            RADIX_HEX: begin
                if (lit_ndig != 0 || d != 0) begin
                    if (lit_ndig >= HEX_DIGITS) begin
                        lit_over = 1'b1;
                    end else begin
                        lit_accum = {lit_accum[59:0], d};
                        lit_ndig  = lit_ndig + 5'd1;
                    end
                end
            end
            RADIX_OCT: begin
                d[3] = 1'b0;
                if (lit_ndig != 0 || d != 0) begin
                    if (lit_ndig >= OCT_DIGITS) begin
                        lit_over = 1'b1;
                    end else begin
                        if (lit_ndig == 0) lit_lead = d[2:0];
                        lit_accum = {lit_accum[60:0], d[2:0]};
                        lit_ndig  = lit_ndig + 5'd1;
                        if (lit_ndig == OCT_DIGITS && lit_lead > 3'd1) lit_over = 1'b1;
                    end
                end
            end
            default: begin
                if (d > 4'd9) d = 4'd9;
                if (!lit_over) begin
                    if (lit_accum > DEC_LIMIT
                            || (lit_accum == DEC_LIMIT && d > (lit_neg ? 4'd8 : 4'd7))) begin
                        lit_over = 1'b1;
                    end else begin
                        lit_accum = lit_accum * 64'd10 + 64'(d);
                    end
                end
            end
        endcase
    endtask

    task automatic send_char(input byte c, input logic f, input logic n);
        if (!quiet && $urandom_range(3, 0) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, n, f, c[6:0]};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        parse_char(c[6:0], f, n);
        chars_sent++;
    endtask

    // negate matters only on the first character; randomize it elsewhere
    task automatic send_text(input string txt, input logic neg, input logic mark_first);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], mark_first && i == 0, i == 0 ? neg : 1'($urandom_range(1, 0)));
        end
    endtask

    function automatic string digit_run(input int n, input logic [1:0] kind, input bit lead_nz);
        string pool;
        string s;
        int    top;
        s = "";
        case (kind)
            RADIX_HEX: pool = "0123456789abcdefABCDEF";
            RADIX_OCT: pool = "01234567";
            default:   pool = "0123456789";
        endcase
        top = pool.len() - 1;
        for (int i = 0; i < n; i++) begin
            s = $sformatf("%s%c", s, pool[$urandom_range(top, (i == 0 && lead_nz) ? 1 : 0)]);
        end
        return s;
    endfunction

    task automatic send_random_literal(input bit near_limit);
        string       body;
        logic [63:0] mag;
        logic        neg;
        int          mangle;
        int          n;
        neg    = 1'($urandom_range(1, 0));
        mangle = near_limit ? 0 : $urandom_range(9, 0);
        case ($urandom_range(2, 0))
            0: begin
                if (near_limit && $urandom_range(1, 0) == 0) begin
                    mag  = DEC_LIMIT * 64'd10 + 64'($urandom_range(9, 0));
                    body = $sformatf("%0d", mag);
                    if ($urandom_range(3, 0) == 0) begin
                        body = {body, digit_run(1, RADIX_DEC, 1'b0)};
                    end
                end else if (near_limit) begin
                    mag  = DEC_LIMIT + 64'($urandom_range(2, 0)) - 64'd1;
                    body = {$sformatf("%0d", mag), digit_run(1, RADIX_DEC, 1'b0)};
                end else begin
                    mag  = {$urandom, $urandom} >> $urandom_range(63, 0);
                    body = $sformatf("%0d", mag);
                end
            end
            1: begin
                body = $urandom_range(1, 0) ? "0x" : "0X";
                repeat ($urandom_range(2, 0)) body = {body, "0"};
                n = near_limit ? $urandom_range(17, 15) : $urandom_range(17, 0);
                body = {body, digit_run(n, RADIX_HEX, 1'b1)};
            end
            default: begin
                body = "0";
                repeat ($urandom_range(2, 0)) body = {body, "0"};
                if (near_limit) begin
                    n    = $urandom_range(23, 21);
                    body = {body, $sformatf("%0d", $urandom_range(3, 1)),
                            digit_run(n - 1, RADIX_OCT, 1'b0)};
                end else begin
                    body = {body, digit_run($urandom_range(23, 0), RADIX_OCT, 1'b1)};
                end
            end
        endcase
        send_text(body, neg, 1'b1);
        if (mangle == 1) send_char(8'($urandom_range(127, 0)), 1'b0, 1'($urandom_range(1, 0)));
        if (mangle != 2) begin
            send_char($urandom_range(1, 0) ? {1'b0, CH_UP_L} : {1'b0, CH_LO_L}, 1'b0, neg);
        end
        if (mangle == 3) begin
            repeat ($urandom_range(3, 1)) begin
                send_char($urandom_range(1, 0) ? 8'($urandom_range(127, 0)) : {1'b0, CH_LO_L},
                          1'b0, 1'($urandom_range(1, 0)));
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle_count);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (parsed_values.size() == 0) begin
                flag_mismatch("unexpected result value", m_tdata, 64'd0);
            end else begin
                want = parsed_values.pop_front();
                if (m_tdata !== want.value) flag_mismatch("value", m_tdata, want.value);
                if (m_tuser[0] !== want.bad) flag_mismatch("bad", 64'(m_tuser[0]), 64'(want.bad));
                if (m_tuser[2:1] !== want.radix) begin
                    flag_mismatch("radix", 64'(m_tuser[2:1]), 64'(want.radix));
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(5, 0) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic test_idle_start();
        send_text("7l", 1'b1, 1'b0);
        send_text("L3l", 1'b0, 1'b0);
        send_text("L", 1'b0, 1'b1);
    endtask

    task automatic test_prefix_forms();
        send_text("0xL", 1'b0, 1'b1);
        send_text("0X1fl", 1'b1, 1'b1);
        send_text("09L", 1'b0, 1'b1);
        send_text("1#AL", 1'b0, 1'b1);
        send_text("0L", 1'b1, 1'b1);
    endtask

    task automatic test_range_limits();
        repeat (12) send_random_literal(1'b1);
    endtask

    task automatic test_mixed_stream();
        while (chars_sent < 380) begin
            if ($urandom_range(7, 0) == 0) begin
                send_char(8'($urandom_range(127, 0)), $urandom_range(3, 0) == 0,
                          1'($urandom_range(1, 0)));
            end else begin
                send_random_literal(1'b0);
            end
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        repeat (5) send_random_literal(1'b0);
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_start();
        test_prefix_forms();
        test_range_limits();
        test_mixed_stream();
        test_back_to_back();
        while (parsed_values.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/llp_pkg.sv
rtl/core/llp_step.sv
rtl/core/long_literal_parser_unit.sv
tb/sv/tb_top.sv
